### hw/rtl/hlt_pkg.sv
// Shared constants, event codes and the table entry record of the liveness table.
package hlt_pkg;

   localparam int TABLE_ENTRIES = 32;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   localparam int ADDR_W       = 32;
   localparam int TIME_W       = 32;
   localparam int GROUP_W      = 8;
   localparam int TOL_W        = 16;
   localparam int NODE_TOTAL_W = 6;
   localparam int HB_W         = 32;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 3;

   // tolerance used when the register holds zero, and the register's reset value
   localparam logic [TOL_W-1:0] TOLERANCE     = 16'd4;
   localparam logic [TOL_W-1:0] TOL_RESET_VAL = 16'd4;

   // register word index
   localparam logic CSR_TOLERANCE = 1'b0;

   typedef enum logic [2:0] {
      EV_SUMMARY = 3'd0,
      EV_NEW     = 3'd1,
      EV_UP      = 3'd2,
      EV_DEAD    = 3'd3,
      EV_FULL    = 3'd4
   } event_kind_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  address;
      logic [TIME_W-1:0]  last_seen;
      logic [TIME_W-1:0]  up_since;
      logic               live;
      logic [GROUP_W-1:0] group;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

### hw/rtl/hlt_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module hlt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic                                          rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold the last read word while no read is issued
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/heartbeat_liveness_table_core.sv
// Top level of the heartbeat liveness table: control sequencer, entry RAM and register port.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+---------------------------------------------
//   req     | in        | req_valid / req_stall | sender_address, now_seconds, group_tag
//   rsp     | out       | rsp_valid / rsp_stall | event_kind, node_address, node_group,
//           |           |                       | up_since, node_total, heartbeat_total,
//           |           |                       | last_of_run
//   csr     | in/out    | psel/penable/pready   | tolerance_seconds at byte address 0
//
// Steps: a heartbeat runs a search pass over the entries in use (one read a cycle, each
//   word compared once it is read out), an update pass (RAM read, then check and write
//   back, per entry), an append step and a summary step; output stalls can hold the
//   update, append and summary steps. The next heartbeat is taken in the idle state after
//   that. The single read port of the entry RAM is why each pass reads one entry at a time.
// Reset clears the entry count, the heartbeat count and the output register's valid bit,
//   and loads the tolerance with 4. The entry RAM is not cleared: only entries below the count are
//   read, and those are always written first.
// Each result waits in the output register while rsp_stall is high; the sequencer holds
//   its step until the register is free. req_stall stays high during reset and for the
//   whole run.
module heartbeat_liveness_table_core
   import hlt_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [ADDR_W-1:0]       req_sender_address,
   input  logic [TIME_W-1:0]       req_now_seconds,
   input  logic [GROUP_W-1:0]      req_group_tag,

   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [2:0]              rsp_event_kind,
   output logic [ADDR_W-1:0]       rsp_node_address,
   output logic [GROUP_W-1:0]      rsp_node_group,
   output logic [TIME_W-1:0]       rsp_up_since,
   output logic [NODE_TOTAL_W-1:0] rsp_node_total,
   output logic [HB_W-1:0]         rsp_heartbeat_total,
   output logic                    rsp_last_of_run,

   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CSR_ADDR_W-1:0]   paddr,
   input  logic [CSR_DATA_W-1:0]   pwdata,
   output logic [CSR_DATA_W-1:0]   prdata,
   output logic                    pready
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIND,
      ST_SCAN_RD,
      ST_SCAN_EV,
      ST_APPEND,
      ST_SUMMARY
   } state_type;

   // ------------------------------------------------------------------
   // Registers and their next values
   // ------------------------------------------------------------------
   state_type            state_ff,    state_in;
   logic [CNT_W-1:0]     rd_idx_ff,   rd_idx_in;
   logic                 chk_ff,      chk_in;
   logic                 found_ff,    found_in;
   logic [CNT_W-1:0]     used_ff,     used_in;
   logic [CNT_W-1:0]     total_ff,    total_in;
   logic [HB_W-1:0]      hb_count_ff, hb_count_in;
   logic [TOL_W-1:0]     tol_ff,      tol_in;
   logic [ADDR_W-1:0]    addr_ff,     addr_in;
   logic [TIME_W-1:0]    now_ff,      now_in;
   logic [GROUP_W-1:0]   tag_ff,      tag_in;

   logic                 rsp_valid_ff,  rsp_valid_in;
   event_kind_type       rsp_kind_ff,   rsp_kind_in;
   logic [ADDR_W-1:0]    rsp_addr_ff,   rsp_addr_in;
   logic [GROUP_W-1:0]   rsp_group_ff,  rsp_group_in;
   logic [TIME_W-1:0]    rsp_since_ff,  rsp_since_in;
   logic [CNT_W-1:0]     rsp_total_ff,  rsp_total_in;
   logic [HB_W-1:0]      rsp_hb_ff,     rsp_hb_in;
   logic                 rsp_last_ff,   rsp_last_in;

   // ------------------------------------------------------------------
   // Entry RAM: one record per known node
   // ------------------------------------------------------------------
   logic                 ram_wr_en;
   logic [IDX_W-1:0]     ram_wr_addr;
   entry_type            ram_wr_data;
   logic                 ram_rd_en;
   logic [IDX_W-1:0]     ram_rd_addr;
   logic [ENTRY_W-1:0]   ram_rd_word;
   entry_type            entry;

   hlt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_word)
   );

   assign entry = entry_type'(ram_rd_word);

   // ------------------------------------------------------------------
   // Register port: a single register at word 0
   // ------------------------------------------------------------------
   logic                 csr_wr;
   logic                 csr_word;

   assign pready   = 1'b1;
   assign csr_word = paddr[2];
   assign csr_wr   = psel & penable & pwrite & pready;

   always_comb begin
      unique case (csr_word)
         CSR_TOLERANCE: prdata = {{(CSR_DATA_W - TOL_W){1'b0}}, tol_ff};
         default:       prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Entry checks
   // ------------------------------------------------------------------
   logic [TOL_W-1:0]     tol_eff;
   logic [TIME_W-1:0]    age;
   logic                 entry_match;
   logic                 entry_expired;
   logic                 table_room;
   logic                 out_free;

   // a zero tolerance acts as the default
   assign tol_eff       = (tol_ff == '0) ? TOLERANCE : tol_ff;
   assign age           = now_ff - entry.last_seen;
   assign entry_match   = (entry.address == addr_ff);
   assign entry_expired = entry.live && (age >= {{(TIME_W - TOL_W){1'b0}}, tol_eff});
   assign table_room    = (used_ff < CNT_W'(TABLE_ENTRIES));
   assign out_free      = !rsp_valid_ff || !rsp_stall;

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   logic                 emit_req;
   logic                 emit_fire;
   event_kind_type       emit_kind;
   logic [ADDR_W-1:0]    emit_addr;
   logic [GROUP_W-1:0]   emit_group;
   logic [TIME_W-1:0]    emit_since;
   logic                 emit_last;

   assign emit_fire = emit_req && out_free;

   always_comb begin
      state_in    = state_ff;
      rd_idx_in   = rd_idx_ff;
      chk_in      = chk_ff;
      found_in    = found_ff;
      used_in     = used_ff;
      total_in    = total_ff;
      hb_count_in = hb_count_ff;
      tol_in      = tol_ff;
      addr_in     = addr_ff;
      now_in      = now_ff;
      tag_in      = tag_ff;

      ram_rd_en   = 1'b0;
      ram_rd_addr = rd_idx_ff[IDX_W-1:0];
      ram_wr_en   = 1'b0;
      ram_wr_addr = rd_idx_ff[IDX_W-1:0];
      ram_wr_data = entry;

      emit_req    = 1'b0;
      emit_kind   = EV_SUMMARY;
      emit_addr   = '0;
      emit_group  = '0;
      emit_since  = '0;
      emit_last   = 1'b0;

      if (csr_wr) begin
         unique case (csr_word)
            CSR_TOLERANCE: tol_in = pwdata[TOL_W-1:0];
            default:       tol_in = tol_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               addr_in     = req_sender_address;
               now_in      = req_now_seconds;
               tag_in      = req_group_tag;
               hb_count_in = hb_count_ff + HB_W'(1);
               rd_idx_in   = '0;
               chk_in      = 1'b0;
               found_in    = 1'b0;
               state_in    = ST_FIND;
            end
         end

         // Search pass: issue one read a cycle, compare the word read in the previous cycle.
         ST_FIND: begin
            if (rd_idx_ff < used_ff) begin
               ram_rd_en = 1'b1;
               rd_idx_in = rd_idx_ff + CNT_W'(1);
               chk_in    = 1'b1;
            end else begin
               chk_in    = 1'b0;
            end
            if (chk_ff && entry_match) begin
               found_in = 1'b1;
            end
            if (!(rd_idx_ff < used_ff) && !chk_ff) begin
               // the count after this heartbeat is known now; every result carries it
               total_in  = used_ff + CNT_W'(!found_ff && table_room);
               rd_idx_in = '0;
               state_in  = ST_SCAN_RD;
            end
         end

         ST_SCAN_RD: begin
            if (rd_idx_ff < used_ff) begin
               ram_rd_en = 1'b1;
               state_in  = ST_SCAN_EV;
            end else begin
               state_in  = ST_APPEND;
            end
         end

         // Update pass: refresh the sender's entry, retire expired live entries.
         ST_SCAN_EV: begin
            if (entry_match) begin
               emit_req   = !entry.live;
               emit_kind  = EV_UP;
               emit_addr  = addr_ff;
               emit_group = tag_ff;
               emit_since = now_ff;
            end else if (entry_expired) begin
               emit_req   = 1'b1;
               emit_kind  = EV_DEAD;
               emit_addr  = entry.address;
               emit_group = entry.group;
               emit_since = entry.up_since;
            end
            if (!emit_req || out_free) begin
               if (entry_match) begin
                  ram_wr_en             = 1'b1;
                  ram_wr_data.last_seen = now_ff;
                  if (!entry.live) begin
                     ram_wr_data.live     = 1'b1;
                     ram_wr_data.up_since = now_ff;
                     ram_wr_data.group    = tag_ff;
                  end
               end else if (entry_expired) begin
                  ram_wr_en        = 1'b1;
                  ram_wr_data.live = 1'b0;
               end
               rd_idx_in = rd_idx_ff + CNT_W'(1);
               state_in  = ST_SCAN_RD;
            end
         end

         ST_APPEND: begin
            if (found_ff) begin
               state_in = ST_SUMMARY;
            end else begin
               emit_req   = 1'b1;
               emit_kind  = table_room ? EV_NEW : EV_FULL;
               emit_addr  = addr_ff;
               emit_group = tag_ff;
               emit_since = table_room ? now_ff : '0;
               if (out_free) begin
                  if (table_room) begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = used_ff[IDX_W-1:0];
                     ram_wr_data = '{address:   addr_ff,
                                     last_seen: now_ff,
                                     up_since:  now_ff,
                                     live:      1'b1,
                                     group:     tag_ff};
                     used_in     = used_ff + CNT_W'(1);
                  end
                  state_in = ST_SUMMARY;
               end
            end
         end

         ST_SUMMARY: begin
            emit_req  = 1'b1;
            emit_kind = EV_SUMMARY;
            emit_last = 1'b1;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Output register: load on a new result, drop after its transfer
   // ------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_group_in = rsp_group_ff;
      rsp_since_in = rsp_since_ff;
      rsp_total_in = rsp_total_ff;
      rsp_hb_in    = rsp_hb_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = emit_kind;
         rsp_addr_in  = emit_addr;
         rsp_group_in = emit_group;
         rsp_since_in = emit_since;
         rsp_total_in = total_ff;
         rsp_hb_in    = hb_count_ff;
         rsp_last_in  = emit_last;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_idx_ff    <= '0;
         chk_ff       <= 1'b0;
         found_ff     <= 1'b0;
         used_ff      <= '0;
         total_ff     <= '0;
         hb_count_ff  <= '0;
         tol_ff       <= TOL_RESET_VAL;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_idx_ff    <= rd_idx_in;
         chk_ff       <= chk_in;
         found_ff     <= found_in;
         used_ff      <= used_in;
         total_ff     <= total_in;
         hb_count_ff  <= hb_count_in;
         tol_ff       <= tol_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff      <= addr_in;
      now_ff       <= now_in;
      tag_ff       <= tag_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_group_ff <= rsp_group_in;
      rsp_since_ff <= rsp_since_in;
      rsp_total_ff <= rsp_total_in;
      rsp_hb_ff    <= rsp_hb_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // ------------------------------------------------------------------
   // Ports
   // ------------------------------------------------------------------
   assign req_stall           = reset || (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_event_kind      = 3'(rsp_kind_ff);
   assign rsp_node_address    = rsp_addr_ff;
   assign rsp_node_group      = rsp_group_ff;
   assign rsp_up_since        = rsp_since_ff;
   assign rsp_node_total      = NODE_TOTAL_W'(rsp_total_ff);
   assign rsp_heartbeat_total = rsp_hb_ff;
   assign rsp_last_of_run     = rsp_last_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !ram_wr_en)
      else $error("entry RAM written while idle");

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_W'(TABLE_ENTRIES))
      else $error("entry count beyond table size");

   a_used_step: assert property (@(posedge clock) disable iff (reset)
      !reset |=> (used_ff == $past(used_ff)) || (used_ff == $past(used_ff) + CNT_W'(1)))
      else $error("entry count moved by more than one");

   a_summary_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff == EV_SUMMARY))
         |-> (rsp_last_ff && (rsp_addr_ff == '0) && (rsp_total_ff == used_ff)))
      else $error("malformed summary result");

endmodule
